// ===== hdl/pcf_pkg.sv =====
// Package with shared types and constants for the partitioned convolution FIR.
package pcf_pkg;

  localparam int MaxTaps = 4096;
  localparam int AddrW = $clog2(MaxTaps);
  localparam int LenW = 13;
  localparam int AccW = 61;

  localparam logic [1:0] CmdSample = 2'd0;
  localparam logic [1:0] CmdWriteTap = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [11:0] tap_index;
    logic signed [23:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] out_sample;
    logic clipped;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_tap;
    logic write_sample;
    logic clear_step;
    logic mac_start;
    logic mac_step;
    logic acc_add;
    logic finish;
    logic bump_pointer;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic mac_last;
  } dp_status_t;

endpackage

// ===== hdl/partitioned_convolution_fir_unit.sv =====
// Top level of the partitioned convolution FIR.
// A sample is computed one tap per cycle on one MAC.
// Tap writes and history clears are followed by a clearing sweep of the history.
// Pass-through items go straight to the output state. One item is in flight at a time.
// Synchronous reset clears length and control, then sweeps the history and the
// taps to zero before the first item is taken.
module partitioned_convolution_fir_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pcf_pkg::in_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output pcf_pkg::out_item_t out_item,
  input  logic cfg_we,
  input  logic [pcf_pkg::LenW-1:0] cfg_data
);

  logic [pcf_pkg::LenW-1:0] response_length;
  pcf_pkg::dp_cmd_t cmd;
  pcf_pkg::dp_status_t status;
  pcf_pkg::in_item_t held;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) response_length <= '0;
    else if (cfg_we) response_length <= cfg_data;
  end

  // Capture the accepted item for later use.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) held <= in_item;
  end

  pcf_controller u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .item(in_item), .response_length,
    .out_valid, .out_ready, .cmd, .status
  );

  pcf_datapath u_dp (
    .clk, .rst, .item((in_valid && in_ready) ? in_item : held),
    .response_length, .cmd, .status, .result(out_item)
  );

endmodule

// ===== hdl/pcf_datapath.sv =====
// Datapath: tap and history memories, multiply-accumulate, rounding and saturation.
module pcf_datapath (
  input  logic clk,
  input  logic rst,
  input  pcf_pkg::in_item_t item,
  input  logic [pcf_pkg::LenW-1:0] response_length,
  input  pcf_pkg::dp_cmd_t cmd,
  output pcf_pkg::dp_status_t status,
  output pcf_pkg::out_item_t result
);

  logic signed [23:0] taps [pcf_pkg::MaxTaps];
  logic signed [23:0] hist [pcf_pkg::MaxTaps];
  logic [pcf_pkg::AddrW-1:0] wp;
  logic [pcf_pkg::AddrW-1:0] clr_addr;
  logic [pcf_pkg::AddrW-1:0] k;
  logic [pcf_pkg::AddrW-1:0] pos;
  logic [pcf_pkg::LenW-1:0] len;
  logic signed [23:0] tap_q;
  logic signed [23:0] hist_q;
  logic signed [47:0] prod;
  logic signed [pcf_pkg::AccW-1:0] acc;
  logic signed [pcf_pkg::AccW-1:0] rounded;
  logic signed [pcf_pkg::AccW-24:0] y;
  logic [pcf_pkg::AddrW:0] k_ext;
  logic tap_wipe;

  // Effective length is clamped to the store depth.
  assign len = (response_length > pcf_pkg::LenW'(pcf_pkg::MaxTaps)) ?
               pcf_pkg::LenW'(pcf_pkg::MaxTaps) : response_length;
  assign k_ext = {1'b0, k} + 1'b1;
  assign status.mac_last = (pcf_pkg::LenW'(k_ext) >= len);
  assign status.clear_done = (clr_addr == '1);

  // Tap memory: zeroed by the sweep that follows reset, then written by tap items.
  always_ff @(posedge clk) begin
    if (cmd.clear_step && tap_wipe) begin
      taps[clr_addr] <= '0;
    end else if (cmd.write_tap) begin
      taps[item.tap_index[pcf_pkg::AddrW-1:0]] <= item.value;
    end
    tap_q <= taps[k];
  end

  // History memory: one port writes samples or clears, the other reads.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      hist[clr_addr] <= '0;
    end else if (cmd.write_sample) begin
      hist[wp] <= item.value;
    end
    hist_q <= hist[pos];
  end

  // Pointers and clear sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      clr_addr <= '0;
      tap_wipe <= 1'b1;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
        wp <= '0;
        if (status.clear_done) tap_wipe <= 1'b0;
      end else if (cmd.bump_pointer) begin
        wp <= wp + 1'b1;
      end
    end
  end

  // Read address walk, one tap per cycle.
  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      k <= '0;
      pos <= wp;
    end else if (cmd.mac_step) begin
      k <= k + 1'b1;
      pos <= pos - 1'b1;
    end
  end

  // Registered product, then accumulate.
  always_ff @(posedge clk) begin
    prod <= tap_q * hist_q;
    if (cmd.mac_start) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + pcf_pkg::AccW'(prod);
    end
  end

  // Round half up, then saturate; a zero response length passes the sample through.
  assign rounded = acc + pcf_pkg::AccW'(64'sh400000);
  assign y = rounded[pcf_pkg::AccW-1:23];

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (response_length == '0) begin
        result.out_sample <= item.value;
        result.clipped <= 1'b0;
      end else if (y > 38'sd8388607) begin
        result.out_sample <= 24'sh7FFFFF;
        result.clipped <= 1'b1;
      end else if (y < -38'sd8388608) begin
        result.out_sample <= 24'sh800000;
        result.clipped <= 1'b1;
      end else begin
        result.out_sample <= y[23:0];
        result.clipped <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/pcf_controller.sv =====
// Controller: sequences commands, clear sweeps and the tap loop.
module pcf_controller (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pcf_pkg::in_item_t item,
  input  logic [pcf_pkg::LenW-1:0] response_length,
  output logic out_valid,
  input  logic out_ready,
  output pcf_pkg::dp_cmd_t cmd,
  input  pcf_pkg::dp_status_t status
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_MAC   = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [1:0] drain, drain_next;
  logic accept;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);
  assign accept = in_valid && in_ready;

  // Output hold register flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      drain <= '0;
    end else begin
      state <= state_next;
      drain <= drain_next;
    end
  end

  // Next state and commands. The drain bits track reads still in the memory and
  // multiplier stages; a product is added once it has passed the read and product registers.
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.acc_add = drain[1];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.cmd)
            pcf_pkg::CmdWriteTap: begin
              cmd.write_tap = 1'b1;
              state_next = S_CLEAR;
            end
            pcf_pkg::CmdClear: state_next = S_CLEAR;
            pcf_pkg::CmdSample: begin
              if (response_length == '0) begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
              end else begin
                cmd.write_sample = 1'b1;
                state_next = S_WRITE;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_WRITE: begin
        cmd.mac_start = 1'b1;
        state_next = S_MAC;
      end
      S_MAC: begin
        // Reads issue now; products land after the read and product registers.
        cmd.mac_step = 1'b1;
        if (status.mac_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!drain[0]) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        cmd.bump_pointer = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    drain_next = {drain[0], cmd.mac_step};
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("item taken while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_valid) else $error("result not raised");
  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && status.clear_done) |=> (state == S_IDLE))
    else $error("clear sweep overran");
`endif

endmodule
